### rtl/waf_pkg.sv
// Package for the weight frame formatter: frame constants, queue entry type
// and small constant tables shared by the front, queue and back modules.
// No dependencies.
`timescale 1ns / 1ps

package waf_pkg;

	// Frame framing bytes and ASCII characters
	localparam logic [7:0] STX_BYTE   = 8'h02;
	localparam logic [7:0] ETX_BYTE   = 8'h03;
	localparam logic [7:0] CMD_BYTE   = 8'h41;
	localparam logic [7:0] ZERO_CHAR  = 8'h30;
	localparam logic [7:0] POINT_CHAR = 8'h2E;
	localparam logic [7:0] MINUS_CHAR = 8'h2D;

	// Saturation limits
	localparam logic signed [15:0] NEG_LIMIT = -16'sd999;
	localparam logic signed [15:0] POS_LIMIT = 16'sd9999;
	localparam logic [13:0] NEG_SAT_MAG = 14'd999;
	localparam logic [13:0] POS_SAT_MAG = 14'd9999;

	// Reciprocal constants for digit extraction
	localparam logic [27:0] RECIP_1000 = 28'd8389;   // / 2^23
	localparam logic [15:0] RECIP_100  = 16'd41;     // / 2^12
	localparam logic [14:0] RECIP_10   = 15'd205;    // / 2^11

	// Byte positions within a frame
	localparam int FRAME_LEN = 9;
	localparam logic [3:0] POS_STX   = 4'd0;
	localparam logic [3:0] POS_SID   = 4'd1;
	localparam logic [3:0] POS_CMD   = 4'd2;
	localparam logic [3:0] POS_CHAR0 = 4'd3;
	localparam logic [3:0] POS_ETX   = 4'(FRAME_LEN - 1);

	// Queue depth between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Decimal point settings
	localparam logic [1:0] DP_ONE = 2'd1;
	localparam logic [1:0] DP_TWO = 2'd2;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_DECIMAL_PLACES = 2'd0,
		REG_STATION_ID     = 2'd1
	} cfg_reg_t;

	// One formatted frame waiting for transmission
	typedef struct packed {
		logic [7:0]      sid;
		logic [4:0][7:0] chars;
	} frame_entry_t;

	// Queue status seen by the back end
	typedef struct packed {
		logic         not_empty;
		frame_entry_t head;
	} queue_status_t;

	function automatic logic [13:0] times_1000(input logic [3:0] d);
		logic [13:0] r;
		case (d)
			4'd0: r = 14'd0;
			4'd1: r = 14'd1000;
			4'd2: r = 14'd2000;
			4'd3: r = 14'd3000;
			4'd4: r = 14'd4000;
			4'd5: r = 14'd5000;
			4'd6: r = 14'd6000;
			4'd7: r = 14'd7000;
			4'd8: r = 14'd8000;
			4'd9: r = 14'd9000;
			default: r = 14'd0;
		endcase
		return r;
	endfunction

	function automatic logic [9:0] times_100(input logic [3:0] d);
		logic [9:0] r;
		case (d)
			4'd0: r = 10'd0;
			4'd1: r = 10'd100;
			4'd2: r = 10'd200;
			4'd3: r = 10'd300;
			4'd4: r = 10'd400;
			4'd5: r = 10'd500;
			4'd6: r = 10'd600;
			4'd7: r = 10'd700;
			4'd8: r = 10'd800;
			4'd9: r = 10'd900;
			default: r = 10'd0;
		endcase
		return r;
	endfunction

	function automatic logic [6:0] times_10(input logic [3:0] d);
		logic [6:0] r;
		case (d)
			4'd0: r = 7'd0;
			4'd1: r = 7'd10;
			4'd2: r = 7'd20;
			4'd3: r = 7'd30;
			4'd4: r = 7'd40;
			4'd5: r = 7'd50;
			4'd6: r = 7'd60;
			4'd7: r = 7'd70;
			4'd8: r = 7'd80;
			4'd9: r = 7'd90;
			default: r = 7'd0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] digit_char(input logic [3:0] d);
		return ZERO_CHAR + {4'd0, d};
	endfunction

endpackage

### rtl/waf_front.sv
// Front end of the weight frame formatter: saturates the weight and splits
// it into decimal digits over three pipeline stages, then formats five chars.
// Depends on waf_pkg.
`timescale 1ns / 1ps

module waf_front import waf_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic signed [15:0]  weight,
	input  logic [1:0]          decimal_places,
	input  logic [7:0]          station_id,
	output logic                push,
	output frame_entry_t        entry
);

	// Stage 1: sign and saturated magnitude
	logic        v_s1;
	logic        neg_s1;
	logic [13:0] mag_s1;
	logic [1:0]  dp_s1;
	logic [7:0]  sid_s1;

	// Stage 2: thousands digit and remainder
	logic        v_s2;
	logic        neg_s2;
	logic [3:0]  d3_s2;
	logic [9:0]  rem_s2;
	logic [1:0]  dp_s2;
	logic [7:0]  sid_s2;

	// Stage 3: hundreds digit and remainder
	logic        v_s3;
	logic        neg_s3;
	logic [3:0]  d3_s3;
	logic [3:0]  d2_s3;
	logic [6:0]  rem_s3;
	logic [1:0]  dp_s3;
	logic [7:0]  sid_s3;

	logic [13:0] mag_c;
	logic [27:0] prod1000;
	logic [3:0]  d3_c;
	logic [13:0] rem1000_c;
	logic [15:0] prod100;
	logic [3:0]  d2_c;
	logic [9:0]  rem100_c;
	logic [14:0] prod10;
	logic [3:0]  d1_c;
	logic [6:0]  rem10_c;
	logic [3:0]  d0_c;
	logic [4:0][7:0] chars_c;

	// Saturate the input magnitude
	always_comb begin
		if (weight[15]) begin
			if (weight < NEG_LIMIT) begin
				mag_c = NEG_SAT_MAG;
			end else begin
				mag_c = 14'(-weight);
			end
		end else if (weight > POS_LIMIT) begin
			mag_c = POS_SAT_MAG;
		end else begin
			mag_c = weight[13:0];
		end
	end

	// Thousands digit by reciprocal multiply
	assign prod1000  = {14'd0, mag_s1} * RECIP_1000;
	assign d3_c      = prod1000[26:23];
	assign rem1000_c = mag_s1 - times_1000(d3_c);

	// Hundreds digit
	assign prod100  = {6'd0, rem_s2} * RECIP_100;
	assign d2_c     = prod100[15:12];
	assign rem100_c = rem_s2 - times_100(d2_c);

	// Tens and units digits
	assign prod10  = {8'd0, rem_s3} * RECIP_10;
	assign d1_c    = prod10[14:11];
	assign rem10_c = rem_s3 - times_10(d1_c);
	assign d0_c    = rem10_c[3:0];

	// Build the five characters and place the decimal point
	always_comb begin
		chars_c[0] = neg_s3 ? MINUS_CHAR : digit_char(d3_s3);
		chars_c[1] = digit_char(d2_s3);
		chars_c[2] = digit_char(d1_c);
		chars_c[3] = digit_char(d0_c);
		chars_c[4] = POINT_CHAR;
		if (dp_s3 == DP_ONE) begin
			chars_c[3] = POINT_CHAR;
			chars_c[4] = digit_char(d0_c);
		end else if (dp_s3 == DP_TWO) begin
			chars_c[2] = POINT_CHAR;
			chars_c[3] = digit_char(d1_c);
			chars_c[4] = digit_char(d0_c);
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		if (accept) begin
			neg_s1 <= weight[15];
			mag_s1 <= mag_c;
			dp_s1  <= decimal_places;
			sid_s1 <= station_id;
		end
		if (v_s1) begin
			neg_s2 <= neg_s1;
			d3_s2  <= d3_c;
			rem_s2 <= rem1000_c[9:0];
			dp_s2  <= dp_s1;
			sid_s2 <= sid_s1;
		end
		if (v_s2) begin
			neg_s3 <= neg_s2;
			d3_s3  <= d3_s2;
			d2_s3  <= d2_c;
			rem_s3 <= rem100_c[6:0];
			dp_s3  <= dp_s2;
			sid_s3 <= sid_s2;
		end
	end

	assign push        = v_s3;
	assign entry.sid   = sid_s3;
	assign entry.chars = chars_c;

endmodule

### rtl/waf_queue.sv
// Short frame queue between the front and back ends of the formatter.
// Depends on waf_pkg.
`timescale 1ns / 1ps

module waf_queue import waf_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  frame_entry_t  push_entry,
	input  logic          pop,
	output queue_status_t status
);

	frame_entry_t       mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  cnt_q;

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Hold entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	assign status.not_empty = (cnt_q != '0);
	assign status.head      = mem_q[rd_ptr_q];

endmodule

### rtl/waf_back.sv
// Back end of the formatter: takes one queued frame and sends its nine bytes,
// one per cycle. Depends on waf_pkg.
`timescale 1ns / 1ps

module waf_back import waf_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  queue_status_t status,
	output logic          pop,
	output logic          byte_valid,
	output logic [7:0]    frame_byte,
	output logic          last_byte
);

	logic         active_q;
	logic [3:0]   idx_q;
	frame_entry_t frame_q;
	logic         at_end;
	logic [3:0]   char_pos;

	assign at_end = active_q && (idx_q == POS_ETX);
	assign pop    = status.not_empty && (!active_q || at_end);

	// Advance the byte counter, load the next frame when idle or at the end of each one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= '0;
		end else if (pop) begin
			active_q <= 1'b1;
			idx_q    <= POS_STX;
		end else if (at_end) begin
			active_q <= 1'b0;
			idx_q    <= '0;
		end else if (active_q) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	// Hold the frame being sent
	always_ff @(posedge clk) begin
		if (pop) begin
			frame_q <= status.head;
		end
	end

	// Select the outgoing byte
	assign char_pos = idx_q - POS_CHAR0;
	always_comb begin
		case (idx_q)
			POS_STX: frame_byte = STX_BYTE;
			POS_SID: frame_byte = frame_q.sid;
			POS_CMD: frame_byte = CMD_BYTE;
			POS_ETX: frame_byte = ETX_BYTE;
			default: frame_byte = frame_q.chars[char_pos[2:0]];
		endcase
	end

	assign byte_valid = active_q;
	assign last_byte  = at_end;

endmodule

### rtl/weight_ascii_frame_formatter.sv
// Top level of the weight frame formatter: configuration registers, request
// credit tracking, and the front / queue / back instances. Depends on waf_pkg.
//
// Usage:
//   Input: drive weight and raise start; a request is taken at a rising edge
//   with start high and busy low. Up to two requests may be taken on
//   consecutive cycles; busy rises when two requests are in flight that the
//   back end has not yet begun to send.
//   Output: each request yields nine bytes, STX, station id, 'A', five
//   characters and ETX, on frame_byte with byte_valid high for one cycle
//   each; last_byte marks ETX. The receiver cannot stall the stream.
//   Order: a taken request passes the front pipeline and the queue before
//   the back end sends its first byte.
//   Frames follow each other with no gap; the one-byte output port sets
//   the sustained request rate.
//   Configuration: cfg_ready is always high; index 0 is decimal_places,
//   index 1 is station_id, other indexes are ignored. The values are sampled
//   when a request is taken.
//   Reset: arst_n clears all control state; decimal_places returns to 0 and
//   station_id to 57. No clearing pass is needed.
`timescale 1ns / 1ps

module weight_ascii_frame_formatter import waf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] weight,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [7:0]         cfg_data,
	output logic               byte_valid,
	output logic [7:0]         frame_byte,
	output logic               last_byte
);

	logic [1:0]        decimal_places_q;
	logic [7:0]        station_id_q;
	logic [QCNT_W-1:0] credit_cnt_q;
	logic              accept;
	logic              push;
	logic              pop;
	frame_entry_t      push_entry;
	queue_status_t     qstatus;

	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign busy      = (credit_cnt_q == QCNT_W'(QDEPTH));

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decimal_places_q <= 2'd0;
			station_id_q     <= 8'd57;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DECIMAL_PLACES: decimal_places_q <= cfg_data[1:0];
				REG_STATION_ID:     station_id_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Track requests taken but not yet handed to the back end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_cnt_q <= '0;
		end else if (accept && !pop) begin
			credit_cnt_q <= credit_cnt_q + 1'b1;
		end else if (pop && !accept) begin
			credit_cnt_q <= credit_cnt_q - 1'b1;
		end
	end

	waf_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.weight         (weight),
		.decimal_places (decimal_places_q),
		.station_id     (station_id_q),
		.push           (push),
		.entry          (push_entry)
	);

	waf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.status     (qstatus)
	);

	waf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.status     (qstatus),
		.pop        (pop),
		.byte_valid (byte_valid),
		.frame_byte (frame_byte),
		.last_byte  (last_byte)
	);

	// Credits never exceed the queue depth
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		credit_cnt_q <= QCNT_W'(QDEPTH))
		else $error("request credit count above queue depth");

	// A frame is only started when a request is outstanding
	a_pop_has_credit: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (credit_cnt_q != '0))
		else $error("frame started with no outstanding request");

	// The closing byte is ETX and is followed by STX or silence
	a_last_is_etx: assert property (@(posedge clk) disable iff (!arst_n)
		last_byte |-> (byte_valid && frame_byte == ETX_BYTE))
		else $error("last byte is not ETX");

	a_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		last_byte |=> (!byte_valid || frame_byte == STX_BYTE))
		else $error("frame after ETX does not start with STX");

endmodule

### tb/tb_top.sv
// Self-checking bench for weight_ascii_frame_formatter: drives weight requests
// and register writes from a stimulus queue and checks every frame byte.
// Depends on waf_pkg and the RTL of the formatter.
`timescale 1ns / 1ps

module tb_top;

	import waf_pkg::cfg_reg_t;
	import waf_pkg::REG_DECIMAL_PLACES;
	import waf_pkg::REG_STATION_ID;
	import waf_pkg::DP_ONE;
	import waf_pkg::DP_TWO;

	// Indexes past the register list; writes there must be ignored
	localparam logic [1:0] REG_SPARE_LO = 2'd2;
	localparam logic [1:0] REG_SPARE_HI = 2'd3;

	// Frame characters, kept independent of the package
	localparam logic [7:0] CH_STX   = 8'h02;
	localparam logic [7:0] CH_ETX   = 8'h03;
	localparam logic [7:0] CH_CMD   = 8'h41;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam int NEG_SAT = 999;
	localparam int POS_SAT = 9999;
	localparam logic [7:0] SID_RESET = 8'd57;

	localparam int FRAME_BYTES = 9;
	localparam int PHASES = 10;
	localparam int PHASE_ITEMS = 50;
	localparam int CYCLE_LIMIT = 200000;

	typedef logic [FRAME_BYTES-1:0][7:0] frame_bytes_t;

	typedef enum logic [1:0] {
		ST_WEIGHT,
		ST_WRITE,
		ST_DRAIN
	} stim_kind_t;

	typedef struct {
		stim_kind_t  kind;
		logic [15:0] weight;
		logic [1:0]  idx;
		logic [7:0]  data;
		int unsigned gap;
	} stim_item_t;

	typedef struct {
		logic [7:0] value;
		logic       last;
	} frame_byte_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic signed [15:0] weight = '0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = REG_DECIMAL_PLACES;
	logic [7:0]         cfg_data = '0;
	logic               byte_valid;
	logic [7:0]         frame_byte;
	logic               last_byte;

	stim_item_t  pending[$];
	frame_byte_t byte_exp[$];

	// Register shadow used by the frame predictor
	logic [1:0] dp_shadow = 2'd0;
	logic [7:0] sid_shadow = SID_RESET;

	int unsigned idle_left = 0;
	int unsigned n_errors = 0;
	int unsigned n_frames = 0;
	int unsigned n_writes = 0;
	int unsigned n_drains = 0;
	int unsigned cycles = 0;

	weight_ascii_frame_formatter u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.weight     (weight),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.byte_valid (byte_valid),
		.frame_byte (frame_byte),
		.last_byte  (last_byte)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Build the nine bytes a weight turns into under the given settings
	function automatic frame_bytes_t format_frame(input logic [15:0] raw, input logic [1:0] dp,
			input logic [7:0] sid);
		frame_bytes_t f;
		logic [4:0][7:0] c;
		int w;
		int m;
		w = $signed(raw);
		if (w < 0) begin
			// negating in int keeps the most negative weight in range, so it saturates
			m = -w;
			c[0] = CH_MINUS;
			if (m > NEG_SAT) begin
				c[1] = CH_NINE;
				c[2] = CH_NINE;
				c[3] = CH_NINE;
			end else begin
				c[1] = CH_ZERO + 8'(m / 100);
				c[2] = CH_ZERO + 8'((m % 100) / 10);
				c[3] = CH_ZERO + 8'(m % 10);
			end
		end else begin
			m = w;
			if (m > POS_SAT) begin
				c[0] = CH_NINE;
				c[1] = CH_NINE;
				c[2] = CH_NINE;
				c[3] = CH_NINE;
			end else begin
				c[0] = CH_ZERO + 8'(m / 1000);
				c[1] = CH_ZERO + 8'((m % 1000) / 100);
				c[2] = CH_ZERO + 8'((m % 100) / 10);
				c[3] = CH_ZERO + 8'(m % 10);
			end
		end
		c[4] = CH_POINT;
		// shift the point left; three places acts like none
		if (dp == DP_ONE) begin
			c[4] = c[3];
			c[3] = CH_POINT;
		end else if (dp == DP_TWO) begin
			c[4] = c[3];
			c[3] = c[2];
			c[2] = CH_POINT;
		end
		f[0] = CH_STX;
		f[1] = sid;
		f[2] = CH_CMD;
		for (int k = 0; k < 5; k++) begin
			f[3 + k] = c[k];
		end
		f[8] = CH_ETX;
		return f;
	endfunction

	function automatic void queue_weight(input logic [15:0] w, input int unsigned gap);
		stim_item_t it;
		it.kind = ST_WEIGHT;
		it.weight = w;
		it.idx = REG_DECIMAL_PLACES;
		it.data = '0;
		it.gap = gap;
		pending.push_back(it);
	endfunction

	function automatic void queue_write(input logic [1:0] idx, input logic [7:0] data);
		stim_item_t it;
		it.kind = ST_WRITE;
		it.weight = '0;
		it.idx = idx;
		it.data = data;
		it.gap = 0;
		pending.push_back(it);
	endfunction

	function automatic void queue_drain();
		stim_item_t it;
		it.kind = ST_DRAIN;
		it.weight = '0;
		it.idx = REG_DECIMAL_PLACES;
		it.data = '0;
		it.gap = 0;
		pending.push_back(it);
	endfunction

	// Pick a weight, weighted toward digit and saturation boundaries
	function automatic logic [15:0] pick_weight();
		logic [15:0] w;
		case ($urandom_range(0, 5))
			0: w = 16'($urandom);
			1: w = 16'($urandom_range(0, 1998) - 999);
			2: w = 16'($urandom_range(0, 9999));
			3: w = 16'($urandom_range(0, 200) - 1100);
			4: w = 16'($urandom_range(9900, 10100));
			default: begin
				case ($urandom_range(0, 7))
					0: w = 16'h8000;
					1: w = 16'h7FFF;
					2: w = 16'h0000;
					3: w = 16'hFFFF;
					4: w = 16'd9999;
					5: w = 16'd10000;
					6: w = 16'(-999);
					default: w = 16'(-1000);
				endcase
			end
		endcase
		return w;
	endfunction

	// Driver: retire handshakes, predict accepted requests, issue the next item
	always @(posedge clk or negedge arst_n) begin : drive_requests
		logic req_taken;
		logic cfg_taken;
		logic nxt_start;
		logic nxt_cfg;
		frame_bytes_t f;
		frame_byte_t fb;
		if (!arst_n) begin
			start <= 1'b0;
			weight <= '0;
			cfg_valid <= 1'b0;
			cfg_index <= REG_DECIMAL_PLACES;
			cfg_data <= '0;
			dp_shadow = 2'd0;
			sid_shadow = SID_RESET;
			idle_left = 0;
		end else begin
			req_taken = start && !busy;
			cfg_taken = cfg_valid && cfg_ready;
			// predict the frame with the settings in force at acceptance
			if (req_taken) begin
				f = format_frame(weight, dp_shadow, sid_shadow);
				for (int k = 0; k < FRAME_BYTES; k++) begin
					fb.value = f[k];
					fb.last = (k == FRAME_BYTES - 1);
					byte_exp.push_back(fb);
				end
			end
			// update the register shadow; spare indexes change nothing
			if (cfg_taken) begin
				n_writes++;
				case (cfg_index)
					REG_DECIMAL_PLACES: dp_shadow = cfg_data[1:0];
					REG_STATION_ID: sid_shadow = cfg_data;
					default: ;
				endcase
			end
			nxt_start = start && !req_taken;
			nxt_cfg = cfg_valid && !cfg_taken;
			if (!nxt_start && !nxt_cfg) begin
				if (idle_left > 0) begin
					idle_left--;
				end else if (pending.size() > 0) begin
					case (pending[0].kind)
						ST_WEIGHT: begin
							weight <= pending[0].weight;
							nxt_start = 1'b1;
							idle_left = pending[0].gap;
							void'(pending.pop_front());
						end
						ST_WRITE: begin
							// write registers only with the block idle
							if (byte_exp.size() == 0) begin
								cfg_index <= pending[0].idx;
								cfg_data <= pending[0].data;
								nxt_cfg = 1'b1;
								void'(pending.pop_front());
							end
						end
						default: begin
							// hold off until every frame byte has come back
							if (byte_exp.size() == 0) begin
								n_drains++;
								void'(pending.pop_front());
							end
						end
					endcase
				end
			end
			start <= nxt_start;
			cfg_valid <= nxt_cfg;
		end
	end

	// Monitor: compare each strobed byte with the oldest prediction
	always @(posedge clk) begin : check_bytes
		frame_byte_t e;
		if (arst_n && byte_valid) begin
			if (byte_exp.size() == 0) begin
				$error("frame_byte: unexpected byte, actual %h", frame_byte);
				n_errors++;
			end else begin
				e = byte_exp.pop_front();
				if (frame_byte !== e.value) begin
					$error("frame_byte: expected %h, actual %h", e.value, frame_byte);
					n_errors++;
				end
				if (last_byte !== e.last) begin
					$error("last_byte: expected %b, actual %b", e.last, last_byte);
					n_errors++;
				end
				if (e.last) begin
					n_frames++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin : run_test
		logic [1:0] dp_val;
		logic [7:0] sid_val;
		int unsigned gap;
		// directed: reset settings first
		queue_weight(16'd0, 0);
		queue_weight(16'd9999, 0);
		queue_weight(16'd10000, 0);
		queue_weight(16'h7FFF, 0);
		queue_weight(16'hFFFF, 0);
		queue_weight(16'(-999), 0);
		queue_weight(16'(-1000), 0);
		queue_weight(16'h8000, 0);
		queue_weight(16'd1234, 0);
		queue_weight(16'(-56), 0);
		// one decimal place, lowest station id
		queue_write(REG_DECIMAL_PLACES, 8'd1);
		queue_write(REG_STATION_ID, 8'd0);
		queue_weight(16'd1234, 0);
		queue_weight(16'(-5), 0);
		queue_weight(16'd9999, 0);
		// two places written with upper data bits set, highest station id
		queue_write(REG_DECIMAL_PLACES, 8'hFE);
		queue_write(REG_STATION_ID, 8'hFF);
		queue_weight(16'd7, 0);
		queue_weight(16'(-999), 0);
		queue_weight(16'd0, 0);
		// spare indexes must leave both registers alone
		queue_write(REG_SPARE_LO, 8'hA5);
		queue_write(REG_SPARE_HI, 8'h5A);
		queue_weight(16'd4321, 0);
		// three places behaves like none
		queue_write(REG_DECIMAL_PLACES, 8'd3);
		queue_weight(16'd5678, 0);
		queue_weight(16'h8000, 0);

		// random phases, each opened by a full drain and new settings
		for (int p = 0; p < PHASES; p++) begin
			queue_drain();
			if (p == 0) begin
				dp_val = 2'd0;
				sid_val = 8'd0;
			end else if (p == 1) begin
				dp_val = 2'd3;
				sid_val = 8'hFF;
			end else begin
				dp_val = 2'($urandom_range(0, 3));
				sid_val = 8'($urandom);
			end
			if ($urandom_range(0, 1) == 0) begin
				queue_write(REG_DECIMAL_PLACES, {6'($urandom), dp_val});
				queue_write(REG_STATION_ID, sid_val);
			end else begin
				queue_write(REG_STATION_ID, sid_val);
				queue_write(REG_DECIMAL_PLACES, {6'($urandom), dp_val});
			end
			if ($urandom_range(0, 3) == 0) begin
				queue_write($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, 8'($urandom));
			end
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// no idling in every third phase and in the last one
				if (p == PHASES - 1 || p % 3 == 1) begin
					gap = 0;
				end else begin
					gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 7) : 0;
				end
				queue_weight(pick_weight(), gap);
				if (p != PHASES - 1 && $urandom_range(0, 39) == 0) begin
					queue_drain();
				end
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// wait for all stimulus to go out and every byte to return
		do begin
			@(negedge clk);
		end while (pending.size() != 0 || start || cfg_valid || byte_exp.size() != 0);
		repeat (20) @(negedge clk);

		$display("Covered %0d frames, %0d register writes, %0d drain pauses, %0d cycles",
			n_frames, n_writes, n_drains, cycles);
		if (n_errors == 0 && byte_exp.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
